// File: sv/segment_hole_fit_allocator_assert.svh
// Assertion macros used by the checker file of the segment hole allocator.
// Each macro expands to one labeled concurrent assertion clocked on clk_i.
// No other file is needed; the user must have clk_i and rst_ni in scope.
`ifndef SEGMENT_HOLE_FIT_ALLOCATOR_ASSERT_SVH
`define SEGMENT_HOLE_FIT_ALLOCATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define SHFA_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define SHFA_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/shfa_pkg.sv
// Package of the segment hole allocator: field widths, codes, enums and structs.
// Used by every RTL file of the block but shfa_hole_mem; depends on nothing.
package shfa_pkg;

  localparam int MAX_HOLES_DEF = 64;
  localparam int ADDR_BITS_DEF = 16;

  localparam int SIZE_W     = 17;
  localparam int SEG_BASE_W = 16;
  localparam int START_W    = 16;
  localparam int PID_W      = 32;
  localparam int SID_W      = 16;
  localparam int POLICY_W   = 2;
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;

  localparam logic [POLICY_W-1:0] FIT_POLICY_RST  = 2'd0;
  localparam logic [SIZE_W-1:0]   MEMORY_SIZE_RST = 17'd4096;

  typedef enum logic {
    CMD_APPEND = 1'b0,
    CMD_ALLOC  = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ST_ALLOCATED = 2'd0,
    ST_NO_FIT    = 2'd1,
    ST_APPENDED  = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    POL_FIRST = 2'd0,
    POL_BEST  = 2'd1,
    POL_WORST = 2'd2
  } policy_e;

  typedef enum logic {
    REG_FIT_POLICY  = 1'b0,
    REG_MEMORY_SIZE = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_SHIFT,
    S_FINISH
  } state_e;

  typedef struct packed {
    logic [POLICY_W-1:0] fit_policy;
    logic [SIZE_W-1:0]   memory_size;
  } cfg_t;

  typedef struct packed {
    status_e               status;
    logic [SEG_BASE_W-1:0] segment_base;
    logic [SIZE_W-1:0]     granted_size;
    logic [PID_W-1:0]      owner_process;
    logic [SID_W-1:0]      owner_segment;
  } res_t;

endpackage

// File: sv/shfa_cmd_if.sv
// Command channel of the segment hole allocator: valid/ready plus one item.
// Depends on shfa_pkg for the field widths.
interface shfa_cmd_if;
  logic                         valid;
  logic                         ready;
  logic                         command;
  logic [shfa_pkg::SIZE_W-1:0]  request_size;
  logic [shfa_pkg::START_W-1:0] hole_start;
  logic [shfa_pkg::PID_W-1:0]   process_id;
  logic [shfa_pkg::SID_W-1:0]   segment_id;

  modport source (
    output valid, command, request_size, hole_start, process_id, segment_id,
    input  ready
  );
  modport sink (
    input  valid, command, request_size, hole_start, process_id, segment_id,
    output ready
  );
endinterface

// File: sv/shfa_res_if.sv
// Result channel of the segment hole allocator: valid/ready plus one item.
// Depends on shfa_pkg for the field widths.
interface shfa_res_if;
  logic                            valid;
  logic                            ready;
  logic [1:0]                      status;
  logic [shfa_pkg::SEG_BASE_W-1:0] segment_base;
  logic [shfa_pkg::SIZE_W-1:0]     granted_size;
  logic [shfa_pkg::PID_W-1:0]      owner_process;
  logic [shfa_pkg::SID_W-1:0]      owner_segment;

  modport source (
    output valid, status, segment_base, granted_size, owner_process, owner_segment,
    input  ready
  );
  modport sink (
    input  valid, status, segment_base, granted_size, owner_process, owner_segment,
    output ready
  );
endinterface

// File: sv/shfa_hole_mem.sv
// Hole table storage: one synchronous memory of {base, size} entries.
// One write port and one read port, read data registered; no package use.
module shfa_hole_mem #(
  parameter int DEPTH  = 64,
  parameter int DATA_W = 33
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [DATA_W-1:0]        rdata_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [DATA_W-1:0]        wdata_i
);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DATA_W-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/shfa_cfg_regs.sv
// APB-style configuration registers: fit policy and managed memory size.
// Depends on shfa_pkg for widths, reset values and register indexes.
module shfa_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [shfa_pkg::PADDR_W-1:0]        paddr,
  input  logic [shfa_pkg::PDATA_W-1:0]        pwdata,
  output logic [shfa_pkg::PDATA_W-1:0]        prdata,
  output logic                                pready,
  output shfa_pkg::cfg_t                      cfg_o
);

  shfa_pkg::cfg_t   cfg_q, cfg_d;
  shfa_pkg::reg_idx_e reg_idx;
  logic             wr_fire;

  // Registers sit four bytes apart, so bit 2 of the address picks one.
  assign reg_idx = shfa_pkg::reg_idx_e'(paddr[2]);
  assign pready  = 1'b1;
  assign wr_fire = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_fire) begin
      case (reg_idx)
        shfa_pkg::REG_FIT_POLICY: begin
          cfg_d.fit_policy = pwdata[shfa_pkg::POLICY_W-1:0];
        end
        shfa_pkg::REG_MEMORY_SIZE: begin
          cfg_d.memory_size = pwdata[shfa_pkg::SIZE_W-1:0];
        end
        default: begin
          cfg_d = cfg_q;
        end
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    case (reg_idx)
      shfa_pkg::REG_FIT_POLICY: begin
        prdata = shfa_pkg::PDATA_W'(cfg_q.fit_policy);
      end
      shfa_pkg::REG_MEMORY_SIZE: begin
        prdata = shfa_pkg::PDATA_W'(cfg_q.memory_size);
      end
      default: begin
        prdata = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fit_policy  <= shfa_pkg::FIT_POLICY_RST;
      cfg_q.memory_size <= shfa_pkg::MEMORY_SIZE_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: sv/shfa_ctrl.sv
// Sequencer of the segment hole allocator: append, fit scan, shrink or removal.
// Depends on shfa_pkg; drives the ports of shfa_hole_mem.
module shfa_ctrl #(
  parameter int MAX_HOLES = shfa_pkg::MAX_HOLES_DEF,
  parameter int ADDR_BITS = shfa_pkg::ADDR_BITS_DEF
) (
  input  logic                                          clk_i,
  input  logic                                          rst_ni,
  input  shfa_pkg::cfg_t                                cfg_i,
  input  logic                                          in_valid_i,
  output logic                                          in_ready_o,
  input  logic                                          command_i,
  input  logic [shfa_pkg::SIZE_W-1:0]                   request_size_i,
  input  logic [shfa_pkg::START_W-1:0]                  hole_start_i,
  input  logic [shfa_pkg::PID_W-1:0]                    process_id_i,
  input  logic [shfa_pkg::SID_W-1:0]                    segment_id_i,
  output logic                                          res_valid_o,
  input  logic                                          res_ready_i,
  output shfa_pkg::res_t                                res_o,
  output logic                                          mem_rd_en_o,
  output logic [$clog2(MAX_HOLES)-1:0]                  mem_rd_addr_o,
  input  logic [ADDR_BITS+shfa_pkg::SIZE_W-1:0]         mem_rdata_i,
  output logic                                          mem_wr_en_o,
  output logic [$clog2(MAX_HOLES)-1:0]                  mem_wr_addr_o,
  output logic [ADDR_BITS+shfa_pkg::SIZE_W-1:0]         mem_wdata_o
);

  localparam int IdxW     = $clog2(MAX_HOLES);
  localparam int CntW     = $clog2(MAX_HOLES + 1);
  localparam int SizeW    = shfa_pkg::SIZE_W;
  localparam int BaseW    = ADDR_BITS;
  localparam int SegBaseW = shfa_pkg::SEG_BASE_W;

  shfa_pkg::state_e      state_q, state_d;
  logic [CntW-1:0]       count_q, count_d;
  logic [CntW-1:0]       ptr_q, ptr_d;
  logic                  chk_valid_q, chk_valid_d;
  logic [IdxW-1:0]       chk_idx_q, chk_idx_d;
  logic                  found_q, found_d;
  logic [IdxW-1:0]       pick_idx_q, pick_idx_d;
  logic [BaseW-1:0]      pick_base_q, pick_base_d;
  logic [SizeW-1:0]      pick_size_q, pick_size_d;
  logic [SizeW-1:0]      req_q, req_d;
  shfa_pkg::res_t        res_q, res_d;

  logic [BaseW-1:0]      ent_base;
  logic [SizeW-1:0]      ent_size;
  logic                  fits;
  logic                  take;
  logic                  found_n;
  logic [IdxW-1:0]       pick_idx_n;
  logic [BaseW-1:0]      pick_base_n;
  logic [SizeW-1:0]      pick_size_n;
  logic [IdxW-1:0]       last_idx;
  logic                  scan_end;
  logic                  shift_end;

  assign ent_base = mem_rdata_i[BaseW+SizeW-1:SizeW];
  assign ent_size = mem_rdata_i[SizeW-1:0];
  assign fits     = ent_size >= req_q;
  assign last_idx = IdxW'(count_q - CntW'(1));

  // Candidate update for the entry whose read data arrives this cycle.
  always_comb begin
    take = 1'b0;
    case (shfa_pkg::policy_e'(cfg_i.fit_policy))
      shfa_pkg::POL_BEST: begin
        take = fits && (!found_q || (ent_size < pick_size_q));
      end
      shfa_pkg::POL_WORST: begin
        take = fits && (!found_q || (ent_size >= pick_size_q));
      end
      default: begin
        take = fits && !found_q;
      end
    endcase
    take = take && chk_valid_q;
  end

  assign found_n     = found_q || take;
  assign pick_idx_n  = take ? chk_idx_q : pick_idx_q;
  assign pick_base_n = take ? ent_base  : pick_base_q;
  assign pick_size_n = take ? ent_size  : pick_size_q;
  assign scan_end    = chk_valid_q && (chk_idx_q == last_idx);
  assign shift_end   = scan_end;

  always_comb begin
    state_d       = state_q;
    count_d       = count_q;
    ptr_d         = ptr_q;
    found_d       = found_q;
    pick_idx_d    = pick_idx_q;
    pick_base_d   = pick_base_q;
    pick_size_d   = pick_size_q;
    req_d         = req_q;
    res_d         = res_q;
    in_ready_o    = 1'b0;
    res_valid_o   = 1'b0;
    mem_rd_en_o   = 1'b0;
    mem_rd_addr_o = '0;
    mem_wr_en_o   = 1'b0;
    mem_wr_addr_o = '0;
    mem_wdata_o   = '0;

    case (state_q)
      shfa_pkg::S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          res_d = '0;
          state_d = shfa_pkg::S_FINISH;
          if (shfa_pkg::cmd_e'(command_i) == shfa_pkg::CMD_APPEND) begin
            if (count_q == CntW'(MAX_HOLES)) begin
              res_d.status = shfa_pkg::ST_FULL;
            end else begin
              res_d.status = shfa_pkg::ST_APPENDED;
              // A zero-sized hole is acknowledged but never stored.
              if (request_size_i != '0) begin
                mem_wr_en_o   = 1'b1;
                mem_wr_addr_o = count_q[IdxW-1:0];
                mem_wdata_o   = {BaseW'(hole_start_i), request_size_i};
                count_d       = count_q + CntW'(1);
              end
            end
          end else begin
            res_d.status        = shfa_pkg::ST_NO_FIT;
            res_d.owner_process = process_id_i;
            res_d.owner_segment = segment_id_i;
            req_d               = request_size_i;
            if ((request_size_i != '0) && (request_size_i <= cfg_i.memory_size) &&
                (count_q != '0)) begin
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = '0;
              ptr_d         = CntW'(1);
              found_d       = 1'b0;
              state_d       = shfa_pkg::S_SCAN;
            end
          end
        end
      end

      shfa_pkg::S_SCAN: begin
        if (ptr_q < count_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = ptr_q[IdxW-1:0];
          ptr_d         = ptr_q + CntW'(1);
        end
        found_d     = found_n;
        pick_idx_d  = pick_idx_n;
        pick_base_d = pick_base_n;
        pick_size_d = pick_size_n;
        if (scan_end) begin
          state_d = shfa_pkg::S_FINISH;
          if (found_n) begin
            res_d.status       = shfa_pkg::ST_ALLOCATED;
            res_d.segment_base = SegBaseW'(pick_base_n);
            res_d.granted_size = req_q;
            if (pick_size_n > req_q) begin
              // Shrink the hole from its bottom.
              mem_wr_en_o   = 1'b1;
              mem_wr_addr_o = pick_idx_n;
              mem_wdata_o   = {pick_base_n + BaseW'(req_q), pick_size_n - req_q};
            end else if (pick_idx_n == last_idx) begin
              count_d = count_q - CntW'(1);
            end else begin
              // Exact fit in the middle: close the gap entry by entry.
              mem_rd_en_o   = 1'b1;
              mem_rd_addr_o = pick_idx_n + IdxW'(1);
              ptr_d         = CntW'(pick_idx_n) + CntW'(2);
              state_d       = shfa_pkg::S_SHIFT;
            end
          end
        end
      end

      shfa_pkg::S_SHIFT: begin
        if (ptr_q < count_q) begin
          mem_rd_en_o   = 1'b1;
          mem_rd_addr_o = ptr_q[IdxW-1:0];
          ptr_d         = ptr_q + CntW'(1);
        end
        if (chk_valid_q) begin
          mem_wr_en_o   = 1'b1;
          mem_wr_addr_o = chk_idx_q - IdxW'(1);
          mem_wdata_o   = mem_rdata_i;
        end
        if (shift_end) begin
          count_d = count_q - CntW'(1);
          state_d = shfa_pkg::S_FINISH;
        end
      end

      shfa_pkg::S_FINISH: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = shfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = shfa_pkg::S_IDLE;
      end
    endcase

    chk_valid_d = mem_rd_en_o;
    chk_idx_d   = mem_rd_addr_o;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= shfa_pkg::S_IDLE;
      count_q     <= '0;
      chk_valid_q <= 1'b0;
      found_q     <= 1'b0;
      ptr_q       <= '0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      chk_valid_q <= chk_valid_d;
      found_q     <= found_d;
      ptr_q       <= ptr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    chk_idx_q   <= chk_idx_d;
    pick_idx_q  <= pick_idx_d;
    pick_base_q <= pick_base_d;
    pick_size_q <= pick_size_d;
    req_q       <= req_d;
    res_q       <= res_d;
  end

  assign res_o = res_q;

endmodule

// File: sv/segment_hole_fit_allocator.sv
// Top level of the segment hole allocator: config registers, sequencer, hole memory.
// Depends on shfa_pkg, shfa_cmd_if, shfa_res_if, shfa_cfg_regs, shfa_ctrl, shfa_hole_mem.

// The block keeps an ordered table of free holes (base, size) in one synchronous
// memory and serves one item at a time. An append item writes the next free
// entry; its result is registered and the sequencer moves to S_FINISH. An allocate item
// that fails the size checks (zero, above memory_size, or an empty table) also
// goes straight to S_FINISH. Otherwise the sequencer reads the table one entry
// per cycle through the memory's single read port; the fit policy only changes
// which candidate is kept, never the scan length. If the chosen hole is used up
// exactly and is not the last one, the entries above it are moved down one place,
// one entry per cycle. Reads and writes of the table never hit the same entry in
// one cycle, because the sequencer orders them. A finished result moves into an
// output register, so the next item is accepted while the previous result still
// waits for the downstream side. Configuration goes through the APB-style port,
// fit_policy at address 0 and memory_size at address 4, and must be written only
// while the block is idle.
module segment_hole_fit_allocator #(
  parameter int MAX_HOLES = shfa_pkg::MAX_HOLES_DEF,
  parameter int ADDR_BITS = shfa_pkg::ADDR_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  shfa_cmd_if.sink                       cmd_i,
  shfa_res_if.source                     res_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [shfa_pkg::PADDR_W-1:0]   paddr,
  input  logic [shfa_pkg::PDATA_W-1:0]   pwdata,
  output logic [shfa_pkg::PDATA_W-1:0]   prdata,
  output logic                           pready
);

  localparam int IdxW = $clog2(MAX_HOLES);
  localparam int EntW = ADDR_BITS + shfa_pkg::SIZE_W;

  shfa_pkg::cfg_t  cfg;
  shfa_pkg::res_t  ctrl_res;
  logic            ctrl_res_valid;
  logic            ctrl_res_ready;

  logic            mem_rd_en;
  logic [IdxW-1:0] mem_rd_addr;
  logic [EntW-1:0] mem_rdata;
  logic            mem_wr_en;
  logic [IdxW-1:0] mem_wr_addr;
  logic [EntW-1:0] mem_wdata;

  logic            out_valid_q, out_valid_d;
  shfa_pkg::res_t  out_q, out_d;

  shfa_cfg_regs u_cfg_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  shfa_ctrl #(
    .MAX_HOLES (MAX_HOLES),
    .ADDR_BITS (ADDR_BITS)
  ) u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg),
    .in_valid_i     (cmd_i.valid),
    .in_ready_o     (cmd_i.ready),
    .command_i      (cmd_i.command),
    .request_size_i (cmd_i.request_size),
    .hole_start_i   (cmd_i.hole_start),
    .process_id_i   (cmd_i.process_id),
    .segment_id_i   (cmd_i.segment_id),
    .res_valid_o    (ctrl_res_valid),
    .res_ready_i    (ctrl_res_ready),
    .res_o          (ctrl_res),
    .mem_rd_en_o    (mem_rd_en),
    .mem_rd_addr_o  (mem_rd_addr),
    .mem_rdata_i    (mem_rdata),
    .mem_wr_en_o    (mem_wr_en),
    .mem_wr_addr_o  (mem_wr_addr),
    .mem_wdata_o    (mem_wdata)
  );

  shfa_hole_mem #(
    .DEPTH  (MAX_HOLES),
    .DATA_W (EntW)
  ) u_hole_mem (
    .clk_i     (clk_i),
    .rd_en_i   (mem_rd_en),
    .rd_addr_i (mem_rd_addr),
    .rdata_o   (mem_rdata),
    .wr_en_i   (mem_wr_en),
    .wr_addr_i (mem_wr_addr),
    .wdata_i   (mem_wdata)
  );

  // Output register: takes a new result whenever it is empty or being drained.
  assign ctrl_res_ready = !out_valid_q || res_o.ready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_d       = out_q;
    if (ctrl_res_valid && ctrl_res_ready) begin
      out_valid_d = 1'b1;
      out_d       = ctrl_res;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q <= out_d;
  end

  assign res_o.valid         = out_valid_q;
  assign res_o.status        = out_q.status;
  assign res_o.segment_base  = out_q.segment_base;
  assign res_o.granted_size  = out_q.granted_size;
  assign res_o.owner_process = out_q.owner_process;
  assign res_o.owner_segment = out_q.owner_segment;

endmodule

// File: sv/shfa_checker.sv
// Port-level checker of the segment hole allocator and its bind to the top level.
// Depends on shfa_pkg and segment_hole_fit_allocator_assert.svh.
`include "segment_hole_fit_allocator_assert.svh"

module shfa_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            res_valid,
  input logic                            res_ready,
  input logic [1:0]                      res_status,
  input logic [shfa_pkg::SEG_BASE_W-1:0] res_base,
  input logic [shfa_pkg::SIZE_W-1:0]     res_size,
  input logic [shfa_pkg::PID_W-1:0]      res_pid,
  input logic [shfa_pkg::SID_W-1:0]      res_sid
);

  logic is_alloc;
  logic is_table_cmd;

  assign is_alloc     = res_status == shfa_pkg::ST_ALLOCATED;
  assign is_table_cmd = (res_status == shfa_pkg::ST_APPENDED) ||
                        (res_status == shfa_pkg::ST_FULL);

  // A stalled result keeps its contents.
  `SHFA_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid && $stable({res_status, res_base, res_size, res_pid, res_sid}), "result changed while stalled")

  // A granted segment always has the nonzero requested size.
  `SHFA_ASSERT_IMP(a_grant_size, res_valid && is_alloc, res_size != '0, "allocation with zero size")

  // Without a grant, base and size stay zero.
  `SHFA_ASSERT_IMP(a_no_grant_zero, res_valid && !is_alloc, (res_base == '0) && (res_size == '0), "nonzero base or size without grant")

  // Table maintenance results carry no owner.
  `SHFA_ASSERT_IMP(a_append_owner, res_valid && is_table_cmd, (res_pid == '0) && (res_sid == '0), "append result carries an owner")

endmodule

bind segment_hole_fit_allocator shfa_checker u_shfa_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .res_valid  (res_o.valid),
  .res_ready  (res_o.ready),
  .res_status (res_o.status),
  .res_base   (res_o.segment_base),
  .res_size   (res_o.granted_size),
  .res_pid    (res_o.owner_process),
  .res_sid    (res_o.owner_segment)
);
